// ===== sv/fmi_pkg.sv =====
// ----------------------------------------------------------------------------
// fmi_pkg
// Shared types and constants for the FM-index search and locate block.
// ----------------------------------------------------------------------------
package fmi_pkg;

    localparam int MAX_ENTRIES  = 65536;
    localparam int ENT_AW       = 16;
    localparam int SAMPLE_SLOTS = 4096;
    localparam int SMP_AW       = 12;
    localparam int MAX_STEPS    = 128;
    localparam int STEP_W       = 8;
    localparam int POS_W        = 17;   // range positions, counts
    localparam int CFG_W        = 17;
    localparam int CFG_IW       = 3;
    localparam int IN_W         = 72;
    localparam int OUT_W        = 72;

    typedef enum logic [2:0] {
        FN_WSYM   = 3'd0,
        FN_WSMP   = 3'd1,
        FN_START  = 3'd2,
        FN_EXTEND = 3'd3,
        FN_LOCATE = 3'd4
    } func_t;

    localparam logic [CFG_IW-1:0] CFG_C_A   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_C_C   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_C_G   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_C_T   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_COUNT = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EXT_SCAN,
        S_LOC_CHK,
        S_LOC_EVAL,
        S_LOC_SCAN,
        S_MRK_SCAN,
        S_SMP_RD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic range_start;
        logic clr_res;
        logic scan_go;
        logic scan_loc;     // scan below e with the symbol just read
        logic ext_upd;
        logic loc_init;
        logic loc_step;
        logic set_err;
        logic ld_pos;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  range_empty;
        logic  scan_done;
        logic  e_oob;
        logic  mark_hit;
        logic  steps_max;
        logic  slot_oob;
        logic  out_free;
    } sts_t;

endpackage

// ===== sv/fm_index_search_and_locate.sv =====
// ----------------------------------------------------------------------------
// fm_index_search_and_locate
// FM-index backward search and locate over a 2-bit DNA BWT.
// ----------------------------------------------------------------------------
// Input items arrive on s_tvalid/s_tready; tuser carries the function code,
// tdata the operands. Write items (symbol with mark, sample) take effect at
// acceptance and give no result. Start, extend and locate give one result
// item on m_tvalid/m_tready. Configuration (C counts, entry count) goes in
// through cfg_we/cfg_index/cfg_data; the user must write it only while the
// block is idle, as the block itself does not enforce this. An extend runs
// one rank scan over min(max(begin,end), used) entries, one entry a cycle.
// A locate runs a rank scan below entry e for each LF step (up to 128
// steps), then the final check, mark scan, sample read and result load.
// The symbol store has a single read port. One item is in work at a time.
// Reset clears the range, the configuration and the control registers;
// store contents are undefined until written. A stalled result stays in
// the output register; write items are still taken meanwhile, and the
// next result waits for it to drain.
// ----------------------------------------------------------------------------
module fm_index_search_and_locate (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // index[15:0], base[17:16], sample_mark[18], sample_value[50:19],
    // which_match[66:51], zero fill
    input  logic [fmi_pkg::IN_W-1:0]          s_tdata,
    // func[2:0]
    input  logic [2:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // range_begin[16:0], range_end[33:17], range_empty[34], position[66:35],
    // walk_error[67], zero fill
    output logic [fmi_pkg::OUT_W-1:0]         m_tdata,
    input  logic                              cfg_we,
    input  logic [fmi_pkg::CFG_IW-1:0]        cfg_index,
    input  logic [fmi_pkg::CFG_W-1:0]         cfg_data
);
    import fmi_pkg::*;

    cmd_t cmd;
    sts_t sts;

    logic [16:0] out_begin, out_end;
    logic        out_empty, out_error;
    logic [31:0] out_position;

    fmi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fmi_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_func      (s_tuser),
        .in_index     (s_tdata[15:0]),
        .in_base      (s_tdata[17:16]),
        .in_mark      (s_tdata[18]),
        .in_sample    (s_tdata[50:19]),
        .in_which     (s_tdata[66:51]),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_begin    (out_begin),
        .out_end      (out_end),
        .out_empty    (out_empty),
        .out_position (out_position),
        .out_error    (out_error)
    );

    assign m_tdata = {4'b0, out_error, out_position, out_empty, out_end, out_begin};

    a_err_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[67] |-> m_tdata[66:35] == 32'd0)
        else $error("error result carries a position");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[34] == (m_tdata[16:0] == m_tdata[33:17]))
        else $error("empty flag disagrees with range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while held");

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_go |-> !s_tready)
        else $error("input ready during a scan");

endmodule

// ===== sv/fmi_ctrl.sv =====
// ----------------------------------------------------------------------------
// fmi_ctrl
// Sequencer for item decode, extend scans and the locate walk.
// ----------------------------------------------------------------------------
module fmi_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  fmi_pkg::sts_t sts,
    output fmi_pkg::cmd_t cmd
);
    import fmi_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (s_tvalid)
                    state_next = S_DECODE;
            S_DECODE:
            begin
                unique case (sts.func)
                    FN_START:  state_next = S_OUT;
                    FN_EXTEND: state_next = sts.range_empty ? S_OUT : S_EXT_SCAN;
                    FN_LOCATE: state_next = S_LOC_CHK;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_EXT_SCAN:
                if (sts.scan_done)
                    state_next = S_OUT;
            S_LOC_CHK:
                state_next = sts.e_oob ? S_OUT : S_LOC_EVAL;
            S_LOC_EVAL:
            begin
                if (sts.mark_hit)
                    state_next = S_MRK_SCAN;
                else if (sts.steps_max)
                    state_next = S_OUT;
                else
                    state_next = S_LOC_SCAN;
            end
            S_LOC_SCAN:
                if (sts.scan_done)
                    state_next = S_LOC_CHK;
            S_MRK_SCAN:
                if (sts.scan_done)
                    state_next = sts.slot_oob ? S_OUT : S_SMP_RD;
            S_SMP_RD:
                state_next = S_OUT;
            S_OUT:
                if (sts.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            S_DECODE:
            begin
                cmd.clr_res = 1'b1;
                unique case (sts.func)
                    FN_START:  cmd.range_start = 1'b1;
                    FN_EXTEND: cmd.scan_go     = !sts.range_empty;
                    FN_LOCATE: cmd.loc_init    = 1'b1;
                    default:   cmd.clr_res     = 1'b1;
                endcase
            end
            S_EXT_SCAN:
                cmd.ext_upd = sts.scan_done;
            S_LOC_CHK:
                cmd.set_err = sts.e_oob;
            S_LOC_EVAL:
            begin
                cmd.scan_loc = 1'b1;
                cmd.scan_go  = sts.mark_hit || !sts.steps_max;
                cmd.set_err  = !sts.mark_hit && sts.steps_max;
            end
            S_LOC_SCAN:
                cmd.loc_step = sts.scan_done;
            S_MRK_SCAN:
                cmd.set_err = sts.scan_done && sts.slot_oob;
            S_SMP_RD:
                cmd.ld_pos = 1'b1;
            S_OUT:
                cmd.out_load = sts.out_free;
            default:
                cmd.clr_res = 1'b0;
        endcase
    end

endmodule

// ===== sv/fmi_dp.sv =====
// ----------------------------------------------------------------------------
// fmi_dp
// Stores, range registers, sequential rank scanner and result register.
// ----------------------------------------------------------------------------
module fmi_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fmi_pkg::cmd_t                cmd,
    output fmi_pkg::sts_t                sts,
    input  logic [2:0]                   in_func,
    input  logic [15:0]                  in_index,
    input  logic [1:0]                   in_base,
    input  logic                         in_mark,
    input  logic [31:0]                  in_sample,
    input  logic [15:0]                  in_which,
    input  logic                         cfg_we,
    input  logic [fmi_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [fmi_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [16:0]                  out_begin,
    output logic [16:0]                  out_end,
    output logic                         out_empty,
    output logic [31:0]                  out_position,
    output logic                         out_error
);
    import fmi_pkg::*;

    localparam logic [POS_W-1:0] USED_MAX = POS_W'(MAX_ENTRIES);
    localparam logic [POS_W-1:0] SLOT_MAX = POS_W'(SAMPLE_SLOTS);
    localparam logic [POS_W-1:0] SAT      = '1;

    // stores
    logic [2:0]  ent_mem [MAX_ENTRIES];     // {mark, symbol}
    logic [31:0] smp_mem [SAMPLE_SLOTS];
    logic [2:0]  ent_rd_reg;
    logic [31:0] smp_rd_reg;
    logic [ENT_AW-1:0] ent_addr;

    // configuration
    logic [CFG_W-1:0] c_reg [4];
    logic [CFG_W-1:0] count_reg;

    // item and range
    func_t       func_reg;
    logic [1:0]  base_reg;
    logic [15:0] which_reg;
    logic [POS_W-1:0] begin_reg, end_reg;

    // locate walk
    logic [POS_W:0]    e_reg;
    logic [STEP_W-1:0] steps_reg;
    logic [31:0]       pos_reg;
    logic              err_reg;

    // scanner
    logic             busy_reg;
    logic [POS_W-1:0] scan_i_reg, lim_reg, a_reg, b_reg, idx_reg;
    logic [POS_W-1:0] cnt_a_reg, cnt_b_reg, mcnt_reg;
    logic [1:0]       sym_reg;
    logic             rd_v_reg;
    logic             issue;
    logic             scan_done;

    // result register
    logic              ov_reg;
    logic [POS_W-1:0]  ob_reg, oe_reg;
    logic [31:0]       op_reg;
    logic              oerr_reg;

    logic [POS_W-1:0] used;
    logic [POS_W-1:0] sa, sb, shi, slim;
    logic [1:0]       ssym;
    logic [POS_W:0]   sum_b, sum_e;
    logic [POS_W-1:0] lf_b, lf_e;

    assign used = (count_reg > USED_MAX) ? USED_MAX : count_reg;

    // scan operands chosen at launch
    always_comb
    begin
        sa   = cmd.scan_loc ? e_reg[POS_W-1:0] : begin_reg;
        sb   = cmd.scan_loc ? e_reg[POS_W-1:0] : end_reg;
        ssym = cmd.scan_loc ? ent_rd_reg[1:0] : base_reg;
        shi  = (sa > sb) ? sa : sb;
        slim = (shi < used) ? shi : used;
    end

    assign issue     = busy_reg && (scan_i_reg < lim_reg);
    assign scan_done = busy_reg && !issue && !rd_v_reg;
    assign ent_addr  = busy_reg ? scan_i_reg[ENT_AW-1:0] : e_reg[ENT_AW-1:0];

    // LF with saturation
    always_comb
    begin
        sum_b = {1'b0, c_reg[sym_reg]} + {1'b0, cnt_a_reg};
        sum_e = {1'b0, c_reg[sym_reg]} + {1'b0, cnt_b_reg};
        lf_b  = sum_b[POS_W] ? SAT : sum_b[POS_W-1:0];
        lf_e  = sum_e[POS_W] ? SAT : sum_e[POS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (func_t'(in_func) == FN_WSYM))
            ent_mem[in_index] <= {in_mark, in_base};
        ent_rd_reg <= ent_mem[ent_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (func_t'(in_func) == FN_WSMP) && ({1'b0, in_index} < SLOT_MAX))
            smp_mem[in_index[SMP_AW-1:0]] <= in_sample;
        smp_rd_reg <= smp_mem[mcnt_reg[SMP_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg[0]  <= '0;
            c_reg[1]  <= '0;
            c_reg[2]  <= '0;
            c_reg[3]  <= '0;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_C_A:   c_reg[0]  <= cfg_data;
                CFG_C_C:   c_reg[1]  <= cfg_data;
                CFG_C_G:   c_reg[2]  <= cfg_data;
                CFG_C_T:   c_reg[3]  <= cfg_data;
                CFG_COUNT: count_reg <= cfg_data;
                default:   count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg  <= func_t'(in_func);
            base_reg  <= in_base;
            which_reg <= in_which;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_reg <= '0;
            end_reg   <= '0;
        end
        else if (cmd.range_start)
        begin
            begin_reg <= '0;
            end_reg   <= count_reg;
        end
        else if (cmd.ext_upd)
        begin
            begin_reg <= lf_b;
            end_reg   <= lf_e;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_res)
        begin
            pos_reg <= '0;
            err_reg <= 1'b0;
        end
        else if (cmd.set_err)
            err_reg <= 1'b1;
        else if (cmd.ld_pos)
            pos_reg <= smp_rd_reg + {{(32-STEP_W){1'b0}}, steps_reg};
        if (cmd.loc_init)
        begin
            e_reg     <= {1'b0, begin_reg} + {2'b0, which_reg};
            steps_reg <= '0;
        end
        else if (cmd.loc_step)
        begin
            e_reg     <= {1'b0, lf_b};
            steps_reg <= steps_reg + 1'b1;
        end
    end

    // rank scan: one entry read per cycle, counts taken in the cycle after the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rd_v_reg <= 1'b0;
        end
        else if (cmd.scan_go)
        begin
            busy_reg <= 1'b1;
            rd_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= issue;
            if (scan_done)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_go)
        begin
            scan_i_reg <= '0;
            lim_reg    <= slim;
            a_reg      <= sa;
            b_reg      <= sb;
            sym_reg    <= ssym;
            cnt_a_reg  <= '0;
            cnt_b_reg  <= '0;
            mcnt_reg   <= '0;
        end
        else
        begin
            if (issue)
                scan_i_reg <= scan_i_reg + 1'b1;
            idx_reg <= scan_i_reg;
            if (rd_v_reg)
            begin
                if ((idx_reg < a_reg) && (ent_rd_reg[1:0] == sym_reg))
                    cnt_a_reg <= cnt_a_reg + 1'b1;
                if ((idx_reg < b_reg) && (ent_rd_reg[1:0] == sym_reg))
                    cnt_b_reg <= cnt_b_reg + 1'b1;
                if ((idx_reg < a_reg) && ent_rd_reg[2])
                    mcnt_reg <= mcnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.out_load)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            ob_reg   <= begin_reg;
            oe_reg   <= end_reg;
            op_reg   <= err_reg ? 32'd0 : pos_reg;
            oerr_reg <= err_reg;
        end
    end

    always_comb
    begin
        sts.func        = func_reg;
        sts.range_empty = (begin_reg == end_reg);
        sts.scan_done   = scan_done;
        sts.e_oob       = (e_reg >= {1'b0, used});
        sts.mark_hit    = ent_rd_reg[2];
        sts.steps_max   = ({1'b0, steps_reg} >= (STEP_W+1)'(MAX_STEPS));
        sts.slot_oob    = (mcnt_reg >= SLOT_MAX);
        sts.out_free    = !ov_reg || out_ready;
    end

    assign out_valid    = ov_reg;
    assign out_begin    = ob_reg;
    assign out_end      = oe_reg;
    assign out_empty    = (ob_reg == oe_reg);
    assign out_position = op_reg;
    assign out_error    = oerr_reg;

endmodule
